FILE: hdl/jep_pkg.sv
// Shared types and constants for the josephus elimination order block.
// No dependencies.
package jep_pkg;

   localparam int ID_W   = 7;
   localparam int STEP_W = 16;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_LOAD   = 2'd1,
      OP_ROTATE = 2'd2,
      OP_REMOVE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type     op;
      logic [ID_W-1:0] head;
      logic [ID_W-1:0] count;
   } cell_ctl_type;

endpackage

FILE: hdl/josephus_elimination_order.sv
// Top level of the josephus elimination order block: control and cell row.
// Depends on jep_pkg, jep_cell, jep_mod.
//
//  channel   ports                                        transfer
//  request   start, busy, req_people_count, req_step      start && !busy
//  response  rsp_valid, rsp_removed_member, rsp_last      rsp_valid, one cycle
//
// Each removal runs the serial remainder unit, then w rotations of the cell
// row, w = (step-1) mod remaining, then the removal itself.
// Synchronous reset returns to idle; no clearing pass.
// The receiver cannot stall; busy stays high until the last result is sent.
module josephus_elimination_order #(
   parameter int MAX_PEOPLE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [jep_pkg::ID_W-1:0]    req_people_count,
   input  logic [jep_pkg::STEP_W-1:0]  req_step,
   output logic                        rsp_valid,
   output logic [jep_pkg::ID_W-1:0]    rsp_removed_member,
   output logic                        rsp_last
);
   import jep_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MOD  = 3'b010,
      ST_WALK = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [ID_W-1:0]   remaining_ff, remaining_in;
   logic [ID_W-1:0]   walk_ff, walk_in;
   logic [STEP_W-1:0] step_less_ff, step_less_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_member_ff, rsp_member_in;
   logic              rsp_last_ff, rsp_last_in;

   cell_ctl_type      ctl;
   logic [ID_W-1:0]   member [MAX_PEOPLE];
   logic              mod_start;
   logic [STEP_W-1:0] mod_dividend;
   logic [ID_W-1:0]   mod_divisor;
   logic              mod_done;
   logic [ID_W-1:0]   mod_rem;
   logic [ID_W-1:0]   n_sat;
   logic              accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign n_sat  = (req_people_count > ID_W'(MAX_PEOPLE)) ? ID_W'(MAX_PEOPLE)
                                                          : req_people_count;

   always_comb begin
      state_in      = state_ff;
      remaining_in  = remaining_ff;
      walk_in       = walk_ff;
      step_less_in  = step_less_ff;
      rsp_valid_in  = 1'b0;
      rsp_member_in = rsp_member_ff;
      rsp_last_in   = rsp_last_ff;
      ctl.op        = OP_HOLD;
      ctl.head      = member[0];
      ctl.count     = remaining_ff;
      mod_start     = 1'b0;
      mod_dividend  = step_less_ff;
      mod_divisor   = remaining_ff - 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_people_count != '0)) begin
               step_less_in = (req_step == '0) ? '0 : req_step - 1'b1;
               remaining_in = n_sat;
               ctl.op       = OP_LOAD;
               mod_start    = 1'b1;
               mod_dividend = step_less_in;
               mod_divisor  = n_sat;
               state_in     = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               walk_in  = mod_rem;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_ff == '0) begin
               ctl.op        = OP_REMOVE;
               rsp_valid_in  = 1'b1;
               rsp_member_in = member[0];
               rsp_last_in   = (remaining_ff == ID_W'(1));
               remaining_in  = remaining_ff - 1'b1;
               if (remaining_ff == ID_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  mod_start = 1'b1;
                  state_in  = ST_MOD;
               end
            end else begin
               ctl.op  = OP_ROTATE;
               walk_in = walk_ff - 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      walk_ff       <= walk_in;
      step_less_ff  <= step_less_in;
      rsp_member_ff <= rsp_member_in;
      rsp_last_ff   <= rsp_last_in;
   end

   jep_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   for (genvar g = 0; g < MAX_PEOPLE; g++) begin : g_cell
      logic [ID_W-1:0] from_next;
      if (g == MAX_PEOPLE - 1) begin : g_end
         assign from_next = '0;
      end else begin : g_mid
         assign from_next = member[g + 1];
      end
      jep_cell #(.INDEX(g)) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .from_next (from_next),
         .member    (member[g])
      );
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_removed_member = rsp_member_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

FILE: hdl/jep_cell.sv
// One slot of the rotating circle: holds one member number.
// Depends on jep_pkg.
module jep_cell #(
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  jep_pkg::cell_ctl_type     ctl,
   input  logic [jep_pkg::ID_W-1:0]  from_next,
   output logic [jep_pkg::ID_W-1:0]  member
);
   import jep_pkg::*;

   logic [ID_W-1:0] member_ff;
   logic [ID_W-1:0] member_in;
   logic            is_tail;

   assign is_tail = (ctl.count == ID_W'(INDEX + 1));

   always_comb begin
      member_in = member_ff;
      unique case (ctl.op)
         OP_HOLD:   member_in = member_ff;
         OP_LOAD:   member_in = ID_W'(INDEX + 1);
         OP_ROTATE: member_in = is_tail ? ctl.head : from_next;
         OP_REMOVE: member_in = from_next;
         default:   member_in = member_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      member_ff <= member_in;
   end

   assign member = member_ff;

endmodule

FILE: hdl/jep_mod.sv
// Bit-serial restoring remainder: dividend mod divisor, one bit per cycle.
// Depends on jep_pkg.
module jep_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [jep_pkg::STEP_W-1:0]  dividend,
   input  logic [jep_pkg::ID_W-1:0]    divisor,
   output logic                        done,
   output logic [jep_pkg::ID_W-1:0]    remainder
);
   import jep_pkg::*;

   localparam int CNT_W = $clog2(STEP_W + 1);

   logic              running_ff, running_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [STEP_W-1:0] shift_ff, shift_in;
   logic [ID_W-1:0]   div_ff, div_in;
   logic [ID_W-1:0]   rem_ff, rem_in;
   logic [ID_W:0]     trial;

   assign trial = {rem_ff, shift_ff[STEP_W-1]};
   assign done  = running_ff && (cnt_ff == '0);

   always_comb begin
      running_in = running_ff;
      cnt_in     = cnt_ff;
      shift_in   = shift_ff;
      div_in     = div_ff;
      rem_in     = rem_ff;
      if (start) begin
         running_in = 1'b1;
         cnt_in     = CNT_W'(STEP_W);
         shift_in   = dividend;
         div_in     = divisor;
         rem_in     = '0;
      end else if (running_ff) begin
         if (cnt_ff == '0) begin
            running_in = 1'b0;
         end else begin
            cnt_in   = cnt_ff - 1'b1;
            shift_in = {shift_ff[STEP_W-2:0], 1'b0};
            if (trial >= {1'b0, div_ff}) begin
               rem_in = ID_W'(trial - {1'b0, div_ff});
            end else begin
               rem_in = ID_W'(trial);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         cnt_ff     <= cnt_in;
      end
      shift_ff <= shift_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   assign remainder = rem_ff;

endmodule

FILE: hdl/jep_checker.sv
// Port-level checks for josephus_elimination_order, bound to the top level.
// Depends on jep_pkg and josephus_elimination_order.
module jep_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [jep_pkg::ID_W-1:0]    req_people_count,
   input logic                        rsp_valid,
   input logic [jep_pkg::ID_W-1:0]    rsp_removed_member,
   input logic                        rsp_last
);
   import jep_pkg::*;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_people_count != '0)) |=> busy)
      else $error("busy not raised after transaction");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("busy after final result");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("idle before final result");

   a_member_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_removed_member != '0))
      else $error("member number zero");

endmodule

bind josephus_elimination_order jep_checker u_jep_checker (.*);
